>>> src/dfcu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dispersive field cell update: shared package
// Widths, configuration register codes and the structs that pass operands
// and stage enables between the modules of the block.
// ----------------------------------------------------------------------------
package dfcu_pkg;

  // Default sizes of the history stores.
  localparam int unsigned CELLS_DEF     = 4096;
  localparam int unsigned MAX_ORDER_DEF = 2;

  // Field widths.
  localparam int unsigned CELL_W     = 12;
  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned COEF_W     = 32;
  localparam int unsigned PROD_W     = SAMPLE_W + COEF_W;
  localparam int unsigned FRAC_SHIFT = 24;
  localparam int unsigned TERM_W     = PROD_W - FRAC_SHIFT;
  localparam int unsigned SUM_W      = TERM_W + 3;

  // Order registers.
  localparam int unsigned ORDER_W     = 2;
  localparam int unsigned ORDER_LIMIT = 2;

  // Configuration port.
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = ORDER_W;

  // Reciprocal used to wrap the cell index when the store is smaller than
  // the index range.
  localparam int unsigned RECIP_SH = 24;
  localparam int unsigned RECIP_W  = RECIP_SH + 1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_FLUX_ORDER  = 1'b0,
    CFG_FIELD_ORDER = 1'b1
  } cfg_reg_e;

  // Operands of one cell that travel down the pipeline.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mean;
    logic signed [SAMPLE_W-1:0] fnow;
    logic signed [COEF_W-1:0]   nc0;
    logic signed [COEF_W-1:0]   nc1;
    logic signed [COEF_W-1:0]   nc2;
    logic signed [COEF_W-1:0]   dc1;
    logic signed [COEF_W-1:0]   dc2;
  } cell_ops_t;

  // Load enables of the arithmetic stages.
  typedef struct packed {
    logic prod;
    logic term;
    logic res;
  } mac_en_t;

endpackage

>>> src/dfcu_hist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dispersive field cell update: history stores
// Per-cell flux and field history memories with registered reads,
// a one-entry bypass for a write that lands in the same cycle as the read,
// and a clearing pass after reset.
// ----------------------------------------------------------------------------
module dfcu_hist #(
  parameter int unsigned CELLS     = dfcu_pkg::CELLS_DEF,
  parameter int unsigned MAX_ORDER = dfcu_pkg::MAX_ORDER_DEF,
  parameter int unsigned IDX_W     = 12
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      rd_en_i,
  input  logic [IDX_W-1:0]                          rd_idx_i,
  input  logic                                      wr_en_i,
  input  logic [IDX_W-1:0]                          wr_idx_i,
  input  logic [MAX_ORDER-1:0][dfcu_pkg::SAMPLE_W-1:0] wr_row_i,
  input  logic [dfcu_pkg::SAMPLE_W-1:0]             wr_field_i,
  output logic [MAX_ORDER-1:0][dfcu_pkg::SAMPLE_W-1:0] rd_row_o,
  output logic [dfcu_pkg::SAMPLE_W-1:0]             rd_field_o,
  output logic                                      busy_o
);
  import dfcu_pkg::*;

  logic                                  clr_busy_q;
  logic [IDX_W-1:0]                      clr_cnt_q;
  logic                                  mem_we;
  logic [IDX_W-1:0]                      mem_addr;
  logic [MAX_ORDER-1:0][SAMPLE_W-1:0]    mem_row;
  logic [SAMPLE_W-1:0]                   mem_field;
  logic [MAX_ORDER-1:0][SAMPLE_W-1:0]    flux_mem_q [CELLS];
  logic [MAX_ORDER-1:0][SAMPLE_W-1:0]    flux_rdata_q;
  logic [MAX_ORDER-1:0][SAMPLE_W-1:0]    fwd_row_q;
  logic [SAMPLE_W-1:0]                   fwd_field_q;
  logic                                  fwd_q;
  logic [SAMPLE_W-1:0]                   field_rdata;

  // Clearing pass: one row per cycle after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_cnt_q == IDX_W'(CELLS - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  assign busy_o = clr_busy_q;

  // The clearing pass owns the write port while it runs.
  always_comb begin
    mem_we    = clr_busy_q | wr_en_i;
    mem_addr  = clr_busy_q ? clr_cnt_q : wr_idx_i;
    mem_row   = clr_busy_q ? '0 : wr_row_i;
    mem_field = clr_busy_q ? '0 : wr_field_i;
  end

  // Flux history: one row of past mean values per cell.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      flux_mem_q[mem_addr] <= mem_row;
    end
    if (rd_en_i) begin
      flux_rdata_q <= flux_mem_q[rd_idx_i];
    end
  end

  // Field history exists only when a second-order term is possible.
  if (MAX_ORDER > 1) begin : g_field
    logic [SAMPLE_W-1:0] field_mem_q [CELLS];
    logic [SAMPLE_W-1:0] field_rdata_q;

    always_ff @(posedge clk_i) begin
      if (mem_we) begin
        field_mem_q[mem_addr] <= mem_field;
      end
      if (rd_en_i) begin
        field_rdata_q <= field_mem_q[rd_idx_i];
      end
    end

    assign field_rdata = field_rdata_q;
  end else begin : g_no_field
    assign field_rdata = '0;
  end

  // A write to the entry being read in the same cycle is captured here,
  // since the memory returns the old contents.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_idx_i == rd_idx_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_row_q   <= wr_row_i;
      fwd_field_q <= wr_field_i;
    end
  end

  assign rd_row_o   = fwd_q ? fwd_row_q : flux_rdata_q;
  assign rd_field_o = fwd_q ? fwd_field_q : field_rdata;

endmodule

>>> src/dfcu_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dispersive field cell update: multiply and accumulate
// Five parallel Q16.16 by Q8.24 products, rounding half up to Q16.16 with
// order gating, then the signed sum saturated into the result register.
// ----------------------------------------------------------------------------
module dfcu_mac (
  input  logic                                 clk_i,
  input  dfcu_pkg::mac_en_t                    en_i,
  input  dfcu_pkg::cell_ops_t                  ops_i,
  input  logic signed [dfcu_pkg::SAMPLE_W-1:0] flux_h1_i,
  input  logic signed [dfcu_pkg::SAMPLE_W-1:0] flux_h2_i,
  input  logic signed [dfcu_pkg::SAMPLE_W-1:0] field_h2_i,
  input  logic [dfcu_pkg::ORDER_W-1:0]         nord_i,
  input  logic [dfcu_pkg::ORDER_W-1:0]         ford_i,
  output logic signed [dfcu_pkg::SAMPLE_W-1:0] field_new_o
);
  import dfcu_pkg::*;

  localparam int unsigned TERMS    = 5;
  localparam int unsigned T_MEAN   = 0;
  localparam int unsigned T_FLUX1  = 1;
  localparam int unsigned T_FLUX2  = 2;
  localparam int unsigned T_FIELD1 = 3;
  localparam int unsigned T_FIELD2 = 4;

  localparam logic signed [SUM_W-1:0] SAT_HI = (SUM_W'(1) <<< (SAMPLE_W - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -(SUM_W'(1) <<< (SAMPLE_W - 1));

  logic signed [PROD_W-1:0]   prod_d [TERMS];
  logic signed [PROD_W-1:0]   prod_q [TERMS];
  logic signed [TERM_W-1:0]   term_d [TERMS];
  logic signed [TERM_W-1:0]   term_q [TERMS];
  logic [TERMS-1:0]           term_use;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SAMPLE_W-1:0] res_d;
  logic signed [SAMPLE_W-1:0] res_q;

  // Round a product half up from Q24 fraction bits to Q16.16.
  function automatic logic signed [TERM_W-1:0] round_term(logic signed [PROD_W-1:0] p);
    logic signed [TERM_W-1:0] hi;
    logic signed [TERM_W-1:0] half;
    hi   = $signed(p[PROD_W-1:FRAC_SHIFT]);
    half = $signed({{(TERM_W - 1){1'b0}}, p[FRAC_SHIFT-1]});
    return hi + half;
  endfunction

  // Products, one multiplier each.
  always_comb begin
    prod_d[T_MEAN]   = ops_i.mean * ops_i.nc0;
    prod_d[T_FLUX1]  = flux_h1_i * ops_i.nc1;
    prod_d[T_FLUX2]  = flux_h2_i * ops_i.nc2;
    prod_d[T_FIELD1] = ops_i.fnow * ops_i.dc1;
    prod_d[T_FIELD2] = field_h2_i * ops_i.dc2;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.prod) begin
      prod_q <= prod_d;
    end
  end

  // Rounding, with terms above the programmed order forced to zero.
  always_comb begin
    term_use[T_MEAN]   = 1'b1;
    term_use[T_FLUX1]  = nord_i >= ORDER_W'(1);
    term_use[T_FLUX2]  = nord_i >= ORDER_W'(2);
    term_use[T_FIELD1] = ford_i >= ORDER_W'(1);
    term_use[T_FIELD2] = ford_i >= ORDER_W'(2);
    for (int i = 0; i < TERMS; i++) begin
      term_d[i] = term_use[i] ? round_term(prod_q[i]) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.term) begin
      term_q <= term_d;
    end
  end

  // Numerator minus denominator, saturated to the sample range.
  always_comb begin
    sum = SUM_W'(term_q[T_MEAN]) + SUM_W'(term_q[T_FLUX1]) + SUM_W'(term_q[T_FLUX2])
        - SUM_W'(term_q[T_FIELD1]) - SUM_W'(term_q[T_FIELD2]);
    if (sum > SAT_HI) begin
      res_d = SAT_HI[SAMPLE_W-1:0];
    end else if (sum < SAT_LO) begin
      res_d = SAT_LO[SAMPLE_W-1:0];
    end else begin
      res_d = sum[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.res) begin
      res_q <= res_d;
    end
  end

  assign field_new_o = res_q;

endmodule

>>> src/dispersive_field_cell_update_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dispersive field cell update core
// Updates one grid cell per item from its flux samples, its current field,
// its coefficients and the per-cell flux and field histories.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake               Payload
//  in       input      in_valid_i / in_stall_o cell_req, flux_a, flux_b, field_now,
//                                              num_coef_0..2, den_coef_1..2
//  out      output     out_valid_o/out_stall_i field_new
//  cfg      input      cfg_we_i                cfg_addr_i, cfg_wdata_i
//
//  One item is accepted per cycle unless stalled; it passes stages 1-5, then the output.
//  The history memories are read, updated and written back once per item,
//  with a one-entry bypass when consecutive items hit the same cell.
//  After reset a clearing pass zeroes every history row; the input stays
//  stalled meanwhile, configuration writes are taken.
//  Each stage holds under a stall and collapses bubbles ahead of it.
// ----------------------------------------------------------------------------
module dispersive_field_cell_update_core #(
  parameter int unsigned CELLS     = dfcu_pkg::CELLS_DEF,
  parameter int unsigned MAX_ORDER = dfcu_pkg::MAX_ORDER_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [dfcu_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [dfcu_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [dfcu_pkg::CELL_W-1:0]          cell_req_i,
  input  logic signed [dfcu_pkg::SAMPLE_W-1:0] flux_a_i,
  input  logic signed [dfcu_pkg::SAMPLE_W-1:0] flux_b_i,
  input  logic signed [dfcu_pkg::SAMPLE_W-1:0] field_now_i,
  input  logic signed [dfcu_pkg::COEF_W-1:0]   num_coef_0_i,
  input  logic signed [dfcu_pkg::COEF_W-1:0]   num_coef_1_i,
  input  logic signed [dfcu_pkg::COEF_W-1:0]   num_coef_2_i,
  input  logic signed [dfcu_pkg::COEF_W-1:0]   den_coef_1_i,
  input  logic signed [dfcu_pkg::COEF_W-1:0]   den_coef_2_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [dfcu_pkg::SAMPLE_W-1:0] field_new_o
);
  import dfcu_pkg::*;

  localparam int unsigned IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam bit          WRAP  = CELLS < (1 << CELL_W);

  logic [ORDER_W-1:0]               flux_order_q;
  logic [ORDER_W-1:0]               field_order_q;
  logic [ORDER_W-1:0]               nord;
  logic [ORDER_W-1:0]               ford;

  logic                             s1_valid_q, s2_valid_q, s3_valid_q;
  logic                             s4_valid_q, s5_valid_q, out_valid_q;
  logic                             en1, en2, en3, en4, en5, en_out;
  logic                             in_accept;
  logic                             clr_busy;

  logic signed [SAMPLE_W:0]         flux_sum;
  cell_ops_t                        ops_d;
  logic [CELL_W-1:0]                s1_cell_q;
  cell_ops_t                        s1_ops_q, s2_ops_q, s3_ops_q;
  logic [IDX_W-1:0]                 idx_d;
  logic [IDX_W-1:0]                 s2_idx_q, s3_idx_q;

  logic [MAX_ORDER-1:0][SAMPLE_W-1:0] hist_row;
  logic [MAX_ORDER-1:0][SAMPLE_W-1:0] new_row;
  logic [SAMPLE_W-1:0]              hist_field;
  logic signed [SAMPLE_W-1:0]       flux_h2;
  logic                             wr_en;
  mac_en_t                          mac_en;

  // Order register above the limit saturates, then caps at MAX_ORDER.
  function automatic logic [ORDER_W-1:0] clamp_order(logic [ORDER_W-1:0] v);
    logic [ORDER_W-1:0] o;
    o = (v > ORDER_W'(ORDER_LIMIT)) ? ORDER_W'(ORDER_LIMIT) : v;
    if (32'(o) > MAX_ORDER) begin
      o = ORDER_W'(MAX_ORDER);
    end
    return o;
  endfunction

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flux_order_q  <= '0;
      field_order_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        CFG_FLUX_ORDER:  flux_order_q  <= cfg_wdata_i;
        CFG_FIELD_ORDER: field_order_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign nord = clamp_order(flux_order_q);
  assign ford = clamp_order(field_order_q);

  // Stage load enables: a stage loads when empty or when its item moves on.
  always_comb begin
    en_out = !out_valid_q || !out_stall_i;
    en5    = !s5_valid_q || en_out;
    en4    = !s4_valid_q || en5;
    en3    = !s3_valid_q || en4;
    en2    = !s2_valid_q || en3;
    en1    = !s1_valid_q || en2;
  end

  assign in_stall_o = clr_busy || !en1;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      s5_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1)    s1_valid_q  <= in_accept;
      if (en2)    s2_valid_q  <= s1_valid_q;
      if (en3)    s3_valid_q  <= s2_valid_q;
      if (en4)    s4_valid_q  <= s3_valid_q;
      if (en5)    s5_valid_q  <= s4_valid_q;
      if (en_out) out_valid_q <= s5_valid_q;
    end
  end

  // Stage 1: mean flux, which is exact as a floor halving.
  always_comb begin
    flux_sum   = (SAMPLE_W + 1)'(flux_a_i) + (SAMPLE_W + 1)'(flux_b_i);
    ops_d.mean = flux_sum[SAMPLE_W:1];
    ops_d.fnow = field_now_i;
    ops_d.nc0  = num_coef_0_i;
    ops_d.nc1  = num_coef_1_i;
    ops_d.nc2  = num_coef_2_i;
    ops_d.dc1  = den_coef_1_i;
    ops_d.dc2  = den_coef_2_i;
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_cell_q <= cell_req_i;
      s1_ops_q  <= ops_d;
    end
  end

  // Cell index wrap. The reciprocal is exact for every twelve-bit index.
  if (WRAP) begin : g_wrap
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** RECIP_SH + CELLS - 1) / CELLS);

    logic [CELL_W+RECIP_W-1:0] qprod;
    logic [CELL_W-1:0]         s1_quot_q;
    logic [CELL_W-1:0]         back;

    assign qprod = (CELL_W + RECIP_W)'(cell_req_i) * (CELL_W + RECIP_W)'(RECIP);

    always_ff @(posedge clk_i) begin
      if (in_accept) begin
        s1_quot_q <= qprod[RECIP_SH +: CELL_W];
      end
    end

    assign back  = CELL_W'(s1_quot_q * CELL_W'(CELLS));
    assign idx_d = IDX_W'(s1_cell_q - back);
  end else begin : g_direct
    assign idx_d = IDX_W'(s1_cell_q);
  end

  // Stage 2 holds the index that addresses the history read.
  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_idx_q <= idx_d;
      s2_ops_q <= s1_ops_q;
    end
  end

  // Stage 3 receives the history and writes the shifted row back.
  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_idx_q <= s2_idx_q;
      s3_ops_q <= s2_ops_q;
    end
  end

  assign wr_en = s3_valid_q && en4;

  always_comb begin
    new_row[0] = s3_ops_q.mean;
    for (int k = 1; k < MAX_ORDER; k++) begin
      new_row[k] = hist_row[k-1];
    end
  end

  dfcu_hist #(
    .CELLS     (CELLS),
    .MAX_ORDER (MAX_ORDER),
    .IDX_W     (IDX_W)
  ) u_hist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (en3),
    .rd_idx_i   (s2_idx_q),
    .wr_en_i    (wr_en),
    .wr_idx_i   (s3_idx_q),
    .wr_row_i   (new_row),
    .wr_field_i (s3_ops_q.fnow),
    .rd_row_o   (hist_row),
    .rd_field_o (hist_field),
    .busy_o     (clr_busy)
  );

  // Flux two steps back exists only with a two-slot row.
  if (MAX_ORDER > 1) begin : g_flux2
    assign flux_h2 = $signed(hist_row[1]);
  end else begin : g_no_flux2
    assign flux_h2 = '0;
  end

  assign mac_en.prod = en4;
  assign mac_en.term = en5;
  assign mac_en.res  = en_out;

  dfcu_mac u_mac (
    .clk_i       (clk_i),
    .en_i        (mac_en),
    .ops_i       (s3_ops_q),
    .flux_h1_i   ($signed(hist_row[0])),
    .flux_h2_i   (flux_h2),
    .field_h2_i  ($signed(hist_field)),
    .nord_i      (nord),
    .ford_i      (ford),
    .field_new_o (field_new_o)
  );

  assign out_valid_o = out_valid_q;

endmodule

>>> src/dfcu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dispersive field cell update: port checker
// Watches the top-level ports: clearing stall after reset, result count
// against accepted items, pipeline occupancy and result hold under stall.
// ----------------------------------------------------------------------------
module dfcu_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [dfcu_pkg::SAMPLE_W-1:0] field_new_o
);
  import dfcu_pkg::*;

  localparam int unsigned DEPTH = 6;

  logic       acc_in;
  logic       acc_out;
  logic [3:0] pending_q;

  assign acc_in  = in_valid_i && !in_stall_o;
  assign acc_out = out_valid_o && !out_stall_i;

  // Items accepted and not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + {3'b000, acc_in} - {3'b000, acc_out};
    end
  end

  // The clearing pass keeps the input stalled right after reset.
  a_clear_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> in_stall_o)
    else $error("input not stalled during clearing pass");

  // A result is never shown without an accepted item behind it.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 4'd0)
    else $error("result without accepted item");

  // The pipeline never holds more items than it has stages.
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 4'(DEPTH))
    else $error("more items in flight than pipeline stages");

  // A stalled result stays and holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(field_new_o))
    else $error("stalled result changed");

endmodule

bind dispersive_field_cell_update_core dfcu_checker u_dfcu_checker (.*);

>>> sim/dispersive_field_cell_update_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dispersive field cell update core: testbench
// Streams grid cells through the core under random input gaps and output
// stalls. A local model of the cell update keeps its own flux and field
// histories and order registers and predicts field_new for every accepted
// item. Each returned value is checked in order against the prediction.
// ----------------------------------------------------------------------------
module dispersive_field_cell_update_core_tb;
  import dfcu_pkg::*;

  localparam int unsigned NCELLS     = CELLS_DEF;
  localparam longint      SAT_MAX    = 64'sd2147483647;
  localparam longint      SAT_MIN    = -64'sd2147483648;
  localparam logic [31:0] Q16_ONE    = 32'h0001_0000;
  localparam logic [31:0] Q24_ONE    = 32'h0100_0000;
  localparam logic [31:0] Q24_HALF   = 32'h0080_0000;
  localparam logic [31:0] Q24_QUART  = 32'h0040_0000;
  localparam logic [31:0] WORD_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] WORD_MIN   = 32'h8000_0000;

  // One grid cell as it is presented to the core.
  typedef struct packed {
    logic [CELL_W-1:0]          cell_idx;
    logic signed [SAMPLE_W-1:0] flux_a;
    logic signed [SAMPLE_W-1:0] flux_b;
    logic signed [SAMPLE_W-1:0] field_now;
    logic signed [COEF_W-1:0]   num0;
    logic signed [COEF_W-1:0]   num1;
    logic signed [COEF_W-1:0]   num2;
    logic signed [COEF_W-1:0]   den1;
    logic signed [COEF_W-1:0]   den2;
  } grid_cell_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [CFG_ADDR_W-1:0]        cfg_addr_i;
  logic [CFG_DATA_W-1:0]        cfg_wdata_i;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic [CELL_W-1:0]            cell_req_i;
  logic signed [SAMPLE_W-1:0]   flux_a_i;
  logic signed [SAMPLE_W-1:0]   flux_b_i;
  logic signed [SAMPLE_W-1:0]   field_now_i;
  logic signed [COEF_W-1:0]     num_coef_0_i;
  logic signed [COEF_W-1:0]     num_coef_1_i;
  logic signed [COEF_W-1:0]     num_coef_2_i;
  logic signed [COEF_W-1:0]     den_coef_1_i;
  logic signed [COEF_W-1:0]     den_coef_2_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic signed [SAMPLE_W-1:0]   field_new_o;

  // Model state: order registers and per-cell histories.
  logic [ORDER_W-1:0]           model_flux_order  = '0;
  logic [ORDER_W-1:0]           model_field_order = '0;
  logic signed [SAMPLE_W-1:0]   model_flux_hist  [NCELLS*2] = '{default: '0};
  logic signed [SAMPLE_W-1:0]   model_field_hist [NCELLS]   = '{default: '0};

  logic signed [SAMPLE_W-1:0]   pending_fields [$];
  int unsigned                  mismatches  = 0;
  bit                           steady_flow = 1'b0;

  dispersive_field_cell_update_core dut (.*);

  // Clock.
  always #5 clk_i = ~clk_i;

  // Downstream stall, random unless a steady stretch is running.
  always @(posedge clk_i) begin
    out_stall_i <= !steady_flow && ($urandom_range(99) < 29);
  end

  // Q16.16 sample times Q8.24 coefficient, rounded half up to Q16.16.
  function automatic longint rounded_term(input longint sample, input longint coef);
    longint prod;
    prod = sample * coef;
    return (prod + (64'sd1 <<< 23)) >>> 24;
  endfunction

  function automatic int unsigned effective_order(input logic [ORDER_W-1:0] code);
    return (code > ORDER_LIMIT) ? ORDER_LIMIT : int'(code);
  endfunction

  // Computes the new field of a cell and shifts that cell's histories.
  function automatic logic signed [SAMPLE_W-1:0] update_cell(input grid_cell_t gc);
    int unsigned c;
    int unsigned nord;
    int unsigned ford;
    longint      mean;
    longint      acc;
    c    = gc.cell_idx % NCELLS;
    nord = effective_order(model_flux_order);
    ford = effective_order(model_field_order);
    mean = (longint'($signed(gc.flux_a)) + longint'($signed(gc.flux_b))) >>> 1;
    acc  = rounded_term(mean, longint'($signed(gc.num0)));
    if (nord >= 1) acc += rounded_term(longint'(model_flux_hist[2*c]), longint'($signed(gc.num1)));
    if (nord >= 2) begin
      acc += rounded_term(longint'(model_flux_hist[2*c+1]), longint'($signed(gc.num2)));
    end
    if (ford >= 1) acc -= rounded_term(longint'($signed(gc.field_now)), longint'($signed(gc.den1)));
    if (ford >= 2) acc -= rounded_term(longint'(model_field_hist[c]), longint'($signed(gc.den2)));
    if (acc > SAT_MAX) acc = SAT_MAX;
    if (acc < SAT_MIN) acc = SAT_MIN;
    // Histories shift on every item, whatever the orders are.
    model_flux_hist[2*c+1] = model_flux_hist[2*c];
    model_flux_hist[2*c]   = mean[SAMPLE_W-1:0];
    model_field_hist[c]    = gc.field_now;
    return acc[SAMPLE_W-1:0];
  endfunction

  // Check every accepted result against the oldest prediction.
  always @(posedge clk_i) begin : result_check
    logic signed [SAMPLE_W-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_fields.size() == 0) begin
        $display("%0t: field_new with no item pending: expected none, actual %h",
                 $time, field_new_o);
        mismatches++;
      end else begin
        want = pending_fields.pop_front();
        if (field_new_o !== want) begin
          $display("%0t: field_new mismatch: expected %h, actual %h",
                   $time, want, field_new_o);
          mismatches++;
        end
      end
    end
  end

  // Present one cell, hold it until accepted, then record its prediction.
  task automatic send_cell(input grid_cell_t gc);
    while (!steady_flow && ($urandom_range(99) < 29)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cell_req_i   <= gc.cell_idx;
    flux_a_i     <= gc.flux_a;
    flux_b_i     <= gc.flux_b;
    field_now_i  <= gc.field_now;
    num_coef_0_i <= gc.num0;
    num_coef_1_i <= gc.num1;
    num_coef_2_i <= gc.num2;
    den_coef_1_i <= gc.den1;
    den_coef_2_i <= gc.den2;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_fields.push_back(update_cell(gc));
  endtask

  // Write both order registers; only called while the core is idle.
  task automatic set_orders(input logic [ORDER_W-1:0] flux_ord,
                            input logic [ORDER_W-1:0] field_ord);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CFG_FLUX_ORDER;
    cfg_wdata_i <= flux_ord;
    @(posedge clk_i);
    cfg_addr_i  <= CFG_FIELD_ORDER;
    cfg_wdata_i <= field_ord;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    model_flux_order  = flux_ord;
    model_field_order = field_ord;
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_fields.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic grid_cell_t make_cell(
    input logic [CELL_W-1:0] cell_idx,
    input logic [31:0] fa, input logic [31:0] fb, input logic [31:0] fnow,
    input logic [31:0] n0, input logic [31:0] n1, input logic [31:0] n2,
    input logic [31:0] d1, input logic [31:0] d2);
    grid_cell_t gc;
    gc = '{cell_idx, fa, fb, fnow, n0, n1, n2, d1, d2};
    return gc;
  endfunction

  // Samples: mostly moderate, some full range, some extremes.
  function automatic logic [31:0] rand_sample();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) return 32'($signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000);
    if (pick < 80) return $urandom;
    case ($urandom_range(4))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      default: return 32'h1;
    endcase
  endfunction

  // Coefficients: mostly within +-2.0, some full range, some extremes.
  function automatic logic [31:0] rand_coef();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 60) return 32'($signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000);
    if (pick < 90) return $urandom;
    return $urandom_range(1) ? WORD_MAX : WORD_MIN;
  endfunction

  // Extremes of every field, on the first, middle and last cell, with saturation.
  task automatic test_field_extremes();
    set_orders(2'd2, 2'd2);
    send_cell(make_cell(12'hFFF, WORD_MAX, WORD_MAX, WORD_MAX,
                        WORD_MAX, WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN));
    send_cell(make_cell(12'h000, WORD_MIN, WORD_MIN, WORD_MIN,
                        WORD_MAX, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN));
    send_cell(make_cell(12'hFFF, 32'h0, 32'h0, 32'h0,
                        32'h0, WORD_MAX, WORD_MAX, 32'h0, WORD_MAX));
    send_cell(make_cell(12'h000, WORD_MAX, WORD_MIN, Q16_ONE,
                        Q24_ONE, Q24_ONE, Q24_ONE, Q24_ONE, Q24_ONE));
    send_cell(make_cell(12'h800, 32'h0, 32'h0, 32'h0,
                        32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
  endtask

  // Back-to-back items, mostly on one cell, so the history bypass is exercised.
  task automatic test_same_cell_chain();
    logic [CELL_W-1:0] chain [6] = '{12'd5, 12'd5, 12'd5, 12'd9, 12'd5, 12'd5};
    steady_flow = 1'b1;
    for (int i = 0; i < 6; i++) begin
      send_cell(make_cell(chain[i], 32'(i * Q16_ONE), 32'(i * Q16_ONE + 3),
                          32'(i * 32'h8000), Q24_ONE, Q24_HALF, Q24_QUART,
                          Q24_QUART, 32'hFF80_0000));
    end
    wait_drained();
    steady_flow = 1'b0;
  endtask

  // Order codes above the limit saturate; the lowest orders drop terms.
  task automatic test_order_codes();
    logic [ORDER_W-1:0] codes [3] = '{2'd3, 2'd0, 2'd1};
    for (int i = 0; i < 3; i++) begin
      wait_drained();
      set_orders(codes[i], codes[i]);
      repeat (2) begin
        send_cell(make_cell(12'd5, 32'h0003_0000, 32'hFFFF_0000, 32'h0002_8000,
                            Q24_HALF, Q24_ONE, 32'hFE00_0000, Q24_HALF, Q24_ONE));
      end
    end
  endtask

  // Mean of an odd sum rounds down; half-way products round up.
  task automatic test_rounding();
    send_cell(make_cell(12'd20, 32'h1, 32'h1, 32'h0, Q24_HALF, 32'h0, 32'h0, 32'h0, 32'h0));
    send_cell(make_cell(12'd21, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0,
                        Q24_HALF, 32'h0, 32'h0, 32'h0, 32'h0));
    send_cell(make_cell(12'd22, 32'hFFFF_FFFD, 32'h0, 32'h0,
                        Q24_ONE, 32'h0, 32'h0, 32'h0, 32'h0));
    send_cell(make_cell(12'd23, 32'h1, 32'h0, 32'h3, Q24_ONE, 32'h0, 32'h0,
                        Q24_HALF, 32'h0));
  endtask

  // Random cells over several order settings. Most items revisit a few
  // cells so that the histories carry real past values.
  task automatic test_random_cells();
    logic [ORDER_W-1:0] flux_plan  [8] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd0, 2'd1, 2'd3};
    logic [ORDER_W-1:0] field_plan [8] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd3, 2'd1};
    logic [CELL_W-1:0]  last_cell;
    logic [CELL_W-1:0]  cell_idx;
    int unsigned        pick;
    last_cell = '0;
    for (int p = 0; p < 8; p++) begin
      wait_drained();
      set_orders(flux_plan[p], field_plan[p]);
      steady_flow = (p == 4);
      for (int n = 0; n < 190; n++) begin
        pick = $urandom_range(99);
        if (pick < 25)      cell_idx = last_cell;
        else if (pick < 70) cell_idx = CELL_W'($urandom_range(7));
        else if (pick < 92) cell_idx = CELL_W'($urandom);
        else                cell_idx = $urandom_range(1) ? '1 : '0;
        last_cell = cell_idx;
        send_cell(make_cell(cell_idx, rand_sample(), rand_sample(), rand_sample(),
                            rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                            rand_coef()));
      end
    end
    steady_flow = 1'b0;
  endtask

  // Main sequence.
  initial begin
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_addr_i   <= CFG_FLUX_ORDER;
    cfg_wdata_i  <= '0;
    in_valid_i   <= 1'b0;
    cell_req_i   <= '0;
    flux_a_i     <= '0;
    flux_b_i     <= '0;
    field_now_i  <= '0;
    num_coef_0_i <= '0;
    num_coef_1_i <= '0;
    num_coef_2_i <= '0;
    den_coef_1_i <= '0;
    den_coef_2_i <= '0;
    out_stall_i  <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_extremes();
    test_same_cell_chain();
    test_order_codes();
    test_rounding();
    test_random_cells();

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("dispersive_field_cell_update_core test passed");
    end else begin
      $display("dispersive_field_cell_update_core test failed");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #2000000;
    $display("dispersive_field_cell_update_core test failed");
    $finish;
  end

endmodule

>>> sim.f
src/dfcu_pkg.sv
src/dfcu_hist.sv
src/dfcu_mac.sv
src/dispersive_field_cell_update_core.sv
src/dfcu_checker.sv
sim/dispersive_field_cell_update_core_tb.sv
